// ===== rtl/core/rgmm_pkg.sv =====
package rgmm_pkg;

	localparam int VAL_W     = 32;
	localparam int ACC_W     = 48;
	localparam int IDX_W     = 12;
	localparam int ROW_W     = 8;
	localparam int CFG_IDX_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MINIMIZE      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_OFFSET    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_CHOICES = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_PLACE      = 4'd3;

	// item actions
	localparam logic ACTION_LOAD  = 1'b0;
	localparam logic ACTION_ENTRY = 1'b1;

	typedef struct packed {
		logic                    action;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] offset;
		logic                    first_in_row;
		logic                    last_in_row;
		logic                    last_in_group;
		logic [ROW_W-1:0]        local_row;
		logic [ROW_W-1:0]        prior_choice;
		logic [IDX_W-1:0]        group_index;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] group_value;
		logic [ROW_W-1:0]        chosen_row;
		logic                    choice_changed;
	} result_t;

	// finished row, accumulator side to selection side
	typedef struct packed {
		logic                    valid;
		logic                    last_group;
		logic [ROW_W-1:0]        local_row;
		logic [ROW_W-1:0]        prior_choice;
		logic signed [ACC_W-1:0] row_value;
	} row_end_t;

	// group decision stage, selection side to top
	typedef struct packed {
		logic                    valid;
		result_t                 res;
		logic signed [VAL_W-1:0] wb_value;
	} sel_out_t;

endpackage

// ===== rtl/core/row_group_min_max_reduce.sv =====
// Row-group min/max reduce. Load x with action-0 beats, then stream sparse matrix
// entries (action 1); each row is offset + sum(coef * x[col]) in Q16.16 with a
// saturating 48-bit accumulator, and each group closes with one result beat that
// carries the best row value and the updated choice. One item is taken every
// cycle when no stall holds it; a result passes through stages s1, s2, s3 and s4
// into an output register that lets the pipeline keep taking items while the
// result waits. The only stalls besides output backpressure are in in-place
// mode: an item whose x address (column or load address) matches a group still
// in flight toward its write-back is held until that write lands, and a load is
// held while a write-back takes the write port. x lives in one X_DEPTH x 32
// memory (one write, one registered read port); entries read before they are
// ever written return garbage. There is no clearing pass after reset.
module row_group_min_max_reduce #(
	parameter int X_DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  rgmm_pkg::item_t                        item,

	output logic                                   result_valid,
	input  logic                                   result_ready,
	output rgmm_pkg::result_t                      result,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rgmm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic                                   cfg_data
);

	localparam int AW    = $clog2(X_DEPTH);
	localparam int DEPTH = 4;    // item accept to group decision
	localparam longint unsigned RECIP = ((64'd1 << 24) + X_DEPTH - 1) / X_DEPTH;

	// index mod X_DEPTH by reciprocal; exact for 12-bit inputs
	function automatic logic [AW-1:0] mod_depth(input logic [rgmm_pkg::IDX_W-1:0] v);
		logic [47:0] q;
		logic [47:0] r;
		q = (48'(v) * 48'(RECIP)) >> 24;
		r = 48'(v) - q * 48'(X_DEPTH);
		if (X_DEPTH >= 4096)
			return AW'(v);
		return AW'(r);
	endfunction

	// config registers
	logic minimize_q;
	logic use_offset_q;
	logic track_choices_q;
	logic in_place_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minimize_q      <= 1'b0;
			use_offset_q    <= 1'b1;
			track_choices_q <= 1'b1;
			in_place_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rgmm_pkg::CFG_MINIMIZE:      minimize_q      <= cfg_data;
				rgmm_pkg::CFG_USE_OFFSET:    use_offset_q    <= cfg_data;
				rgmm_pkg::CFG_TRACK_CHOICES: track_choices_q <= cfg_data;
				rgmm_pkg::CFG_IN_PLACE:      in_place_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	rgmm_pkg::sel_out_t sel_out;
	rgmm_pkg::row_end_t row_end;
	logic               adv;
	logic               hazard;
	logic               item_fire;
	logic               load_fire;
	logic               entry_fire;
	logic               wb_fire;
	logic [AW-1:0]      addr_idx;
	logic [AW-1:0]      addr_grp;

	// pending in-place write-backs, one slot per stage
	logic               pend_v_q [DEPTH];
	logic [AW-1:0]      pend_a_q [DEPTH];

	logic                               result_valid_q;
	rgmm_pkg::result_t                  result_q;

	logic                               mem_we;
	logic [AW-1:0]                      mem_wa;
	logic [rgmm_pkg::VAL_W-1:0]         mem_wd;
	logic [rgmm_pkg::VAL_W-1:0]         xval;

	assign addr_idx = mod_depth(item.index);
	assign addr_grp = mod_depth(item.group_index);

	// stages move unless a decided group is blocked by a full output register
	assign adv = !sel_out.valid || !result_valid_q || result_ready;

	always_comb begin
		hazard = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pend_v_q[i] && pend_a_q[i] == addr_idx)
				hazard = 1'b1;
		end
		// write port is busy with the write-back this cycle
		if (pend_v_q[DEPTH-1] && item.action == rgmm_pkg::ACTION_LOAD)
			hazard = 1'b1;
	end

	assign item_ready = adv & !hazard;
	assign item_fire  = item_valid & item_ready;
	assign load_fire  = item_fire & (item.action == rgmm_pkg::ACTION_LOAD);
	assign entry_fire = item_fire & (item.action == rgmm_pkg::ACTION_ENTRY);
	assign wb_fire    = adv & pend_v_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				pend_v_q[i] <= 1'b0;
		end else if (adv) begin
			pend_v_q[0] <= entry_fire & item.last_in_group & in_place_q;
			for (int i = 1; i < DEPTH; i++)
				pend_v_q[i] <= pend_v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pend_a_q[0] <= addr_grp;
			for (int i = 1; i < DEPTH; i++)
				pend_a_q[i] <= pend_a_q[i-1];
		end
	end

	// x memory: loads and write-backs share the write port
	assign mem_we = load_fire | wb_fire;
	assign mem_wa = wb_fire ? pend_a_q[DEPTH-1] : addr_idx;
	assign mem_wd = wb_fire ? sel_out.wb_value : item.value;

	rgmm_xmem #(
		.DEPTH (X_DEPTH),
		.AW    (AW)
	) u_xmem (
		.clk (clk),
		.we  (mem_we),
		.wa  (mem_wa),
		.wd  (mem_wd),
		.re  (entry_fire),
		.ra  (addr_idx),
		.rd  (xval)
	);

	rgmm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.load_en    (entry_fire),
		.item       (item),
		.xval       (xval),
		.use_offset (use_offset_q),
		.row_end    (row_end)
	);

	rgmm_select u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.row_end       (row_end),
		.minimize      (minimize_q),
		.track_choices (track_choices_q),
		.sel_out       (sel_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (adv && sel_out.valid)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && sel_out.valid)
			result_q <= sel_out.res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	// a load never collides with a write-back on the single write port
	a_wport_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_fire && wb_fire))
		else $error("load and write-back on the same cycle");

	// write-back tracker stays aligned with the decision stage
	a_wb_align: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q[DEPTH-1] |-> sel_out.valid)
		else $error("write-back slot without a decided group");

	// a blocked decision is not lost
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sel_out.valid && !adv |=> sel_out.valid)
		else $error("decided group dropped while stalled");

	// untracked choices report zero
	a_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !track_choices_q |->
			result_q.chosen_row == '0 && !result_q.choice_changed)
		else $error("choice reported while not tracked");
`endif

endmodule

// ===== rtl/core/rgmm_xmem.sv =====
module rgmm_xmem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 wa,
	input  logic [rgmm_pkg::VAL_W-1:0]    wd,
	input  logic                          re,
	input  logic [AW-1:0]                 ra,
	output logic [rgmm_pkg::VAL_W-1:0]    rd
);

	logic [rgmm_pkg::VAL_W-1:0] mem [DEPTH];
	logic [rgmm_pkg::VAL_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (re)
			rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

// ===== rtl/core/rgmm_mac.sv =====
module rgmm_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          load_en,
	input  rgmm_pkg::item_t               item,
	input  logic [rgmm_pkg::VAL_W-1:0]    xval,
	input  logic                          use_offset,
	output rgmm_pkg::row_end_t            row_end
);

	localparam int AW_ = rgmm_pkg::ACC_W;
	localparam logic signed [AW_-1:0] ACC_MAX = {1'b0, {(AW_-1){1'b1}}};
	localparam logic signed [AW_-1:0] ACC_MIN = {1'b1, {(AW_-1){1'b0}}};

	// s1: coefficient waits for the x read
	logic                                 v_s1;
	logic signed [rgmm_pkg::VAL_W-1:0]    coef_s1;
	logic signed [rgmm_pkg::VAL_W-1:0]    off_s1;
	logic                                 first_s1;
	logic                                 end_s1;
	logic                                 lg_s1;
	logic [rgmm_pkg::ROW_W-1:0]           lrow_s1;
	logic [rgmm_pkg::ROW_W-1:0]           prior_s1;

	// s2: product ready, accumulate
	logic                                 v_s2;
	logic signed [AW_-1:0]                prod_s2;
	logic signed [rgmm_pkg::VAL_W-1:0]    off_s2;
	logic                                 first_s2;
	logic                                 end_s2;
	logic                                 lg_s2;
	logic [rgmm_pkg::ROW_W-1:0]           lrow_s2;
	logic [rgmm_pkg::ROW_W-1:0]           prior_s2;

	logic signed [AW_-1:0]                acc_q;
	logic signed [2*rgmm_pkg::VAL_W-1:0]  prod;
	logic signed [AW_-1:0]                base;
	logic signed [AW_:0]                  sum;
	logic signed [AW_-1:0]                acc_sum;

	// Q16.16 x Q16.16, floor to Q.16
	assign prod = coef_s1 * $signed(xval);

	always_comb begin
		if (first_s2)
			base = use_offset ? {{(AW_-rgmm_pkg::VAL_W){off_s2[rgmm_pkg::VAL_W-1]}}, off_s2}
			                  : '0;
		else
			base = acc_q;
		sum = {base[AW_-1], base} + {prod_s2[AW_-1], prod_s2};
		if (sum[AW_] != sum[AW_-1])
			acc_sum = sum[AW_] ? ACC_MIN : ACC_MAX;
		else
			acc_sum = sum[AW_-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else if (adv) begin
			v_s1 <= load_en;
			v_s2 <= v_s1;
			if (v_s2)
				acc_q <= end_s2 ? '0 : acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (load_en) begin
				coef_s1  <= item.value;
				off_s1   <= item.offset;
				first_s1 <= item.first_in_row;
				end_s1   <= item.last_in_row | item.last_in_group;
				lg_s1    <= item.last_in_group;
				lrow_s1  <= item.local_row;
				prior_s1 <= item.prior_choice;
			end
			if (v_s1) begin
				prod_s2  <= prod[2*rgmm_pkg::VAL_W-1:16];
				off_s2   <= off_s1;
				first_s2 <= first_s1;
				end_s2   <= end_s1;
				lg_s2    <= lg_s1;
				lrow_s2  <= lrow_s1;
				prior_s2 <= prior_s1;
			end
		end
	end

	assign row_end.valid        = v_s2 & end_s2;
	assign row_end.last_group   = lg_s2;
	assign row_end.local_row    = lrow_s2;
	assign row_end.prior_choice = prior_s2;
	assign row_end.row_value    = acc_sum;

endmodule

// ===== rtl/core/rgmm_select.sv =====
module rgmm_select (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  rgmm_pkg::row_end_t    row_end,
	input  logic                  minimize,
	input  logic                  track_choices,
	output rgmm_pkg::sel_out_t    sel_out
);

	localparam int AW_ = rgmm_pkg::ACC_W;
	localparam int VW  = rgmm_pkg::VAL_W;
	localparam int RW  = rgmm_pkg::ROW_W;

	function automatic logic beats(input logic signed [AW_-1:0] a,
	                               input logic signed [AW_-1:0] b,
	                               input logic mn);
		return mn ? (a < b) : (a > b);
	endfunction

	// s3: finished row
	logic                     v_s3;
	logic signed [AW_-1:0]    rv_s3;
	logic                     lg_s3;
	logic [RW-1:0]            lrow_s3;
	logic [RW-1:0]            prior_s3;

	// running group state
	logic signed [AW_-1:0]    best_q;
	logic [RW-1:0]            brow_q;
	logic signed [AW_-1:0]    pv_q;
	logic                     seen_q;
	logic                     has_q;

	// s4: closed group
	logic                     v_s4;
	logic signed [AW_-1:0]    best_s4;
	logic [RW-1:0]            brow_s4;
	logic signed [AW_-1:0]    pv_s4;
	logic                     seen_s4;
	logic [RW-1:0]            prior_s4;

	logic                     is_prior;
	logic                     upd;
	logic signed [AW_-1:0]    best_n;
	logic [RW-1:0]            brow_n;
	logic signed [AW_-1:0]    pv_n;
	logic                     seen_n;
	logic                     take;
	logic [RW-1:0]            chosen;

	always_comb begin
		is_prior = (lrow_s3 == prior_s3);
		pv_n     = is_prior ? rv_s3 : pv_q;
		seen_n   = seen_q | is_prior;
		// strict improvement only: ties keep the earlier row
		upd      = !has_q || beats(rv_s3, best_q, minimize);
		best_n   = upd ? rv_s3 : best_q;
		brow_n   = upd ? lrow_s3 : brow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			best_q <= '0;
			brow_q <= '0;
			pv_q   <= '0;
			seen_q <= 1'b0;
			has_q  <= 1'b0;
		end else if (adv) begin
			v_s3 <= row_end.valid;
			v_s4 <= v_s3 & lg_s3;
			if (v_s3) begin
				if (lg_s3) begin
					best_q <= '0;
					brow_q <= '0;
					pv_q   <= '0;
					seen_q <= 1'b0;
					has_q  <= 1'b0;
				end else begin
					best_q <= best_n;
					brow_q <= brow_n;
					pv_q   <= pv_n;
					seen_q <= seen_n;
					has_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (row_end.valid) begin
				rv_s3    <= row_end.row_value;
				lg_s3    <= row_end.last_group;
				lrow_s3  <= row_end.local_row;
				prior_s3 <= row_end.prior_choice;
			end
			if (v_s3 && lg_s3) begin
				best_s4  <= best_n;
				brow_s4  <= brow_n;
				pv_s4    <= pv_n;
				seen_s4  <= seen_n;
				prior_s4 <= prior_s3;
			end
		end
	end

	always_comb begin
		take   = !seen_s4 || beats(best_s4, pv_s4, minimize);
		chosen = track_choices ? (take ? brow_s4 : prior_s4) : '0;
		sel_out.valid              = v_s4;
		sel_out.res.group_value    = best_s4;
		sel_out.res.chosen_row     = chosen;
		sel_out.res.choice_changed = track_choices & (chosen != prior_s4);
		// write-back value clamps to 32 bits
		if (best_s4[AW_-1:VW-1] == {(AW_-VW+1){1'b0}} ||
		    best_s4[AW_-1:VW-1] == {(AW_-VW+1){1'b1}})
			sel_out.wb_value = best_s4[VW-1:0];
		else
			sel_out.wb_value = best_s4[AW_-1] ? {1'b1, {(VW-1){1'b0}}}
			                                  : {1'b0, {(VW-1){1'b1}}};
	end

endmodule
